// File: hw/rtl/mprt_pkg.sv
// Package for the mesh parent route table: sizes, codes and shared types.
package mprt_pkg;

  localparam int unsigned MaxEntries = 16;
  localparam int unsigned MaxHops    = 8;
  localparam int unsigned IdxW       = $clog2(MaxEntries);
  localparam int unsigned CntW       = $clog2(MaxEntries + 1);
  localparam int unsigned HopW       = 6;

  // Command codes.
  localparam logic [1:0] CmdSet   = 2'd0;
  localparam logic [1:0] CmdGet   = 2'd1;
  localparam logic [1:0] CmdClear = 2'd2;
  localparam logic [1:0] CmdTrace = 2'd3;

  // Status codes for set parent.
  localparam logic [2:0] StError     = 3'd0;
  localparam logic [2:0] StIdentical = 3'd1;
  localparam logic [2:0] StRejected  = 3'd2;
  localparam logic [2:0] StChanged   = 3'd3;
  localparam logic [2:0] StCreated   = 3'd4;

  // Configuration register indexes.
  localparam logic [1:0] RegOwn   = 2'd0;
  localparam logic [1:0] RegBcast = 2'd1;
  localparam logic [1:0] RegLive  = 2'd2;

  // Kinds of output word.
  localparam logic [1:0] OutRead  = 2'd0;
  localparam logic [1:0] OutClear = 2'd1;
  localparam logic [1:0] OutHop   = 2'd2;
  localparam logic [1:0] OutFinal = 2'd3;

  typedef enum logic [3:0] {
    StIdle,
    StScanPar,
    StScanDev,
    StDecide,
    StWrite,
    StReadOut,
    StEmit,
    StTrScan,
    StTrStep,
    StTrEmit
  } state_e;

  // Commands from controller to datapath.
  typedef struct packed {
    logic       load;       // capture the input word
    logic       scan_start; // reset scan index
    logic       scan_step;  // compare one entry, advance
    logic       scan_par;   // scan looks for parent (else for target)
    logic       latch_par;  // keep parent match result
    logic       create;     // append new entry
    logic       update;     // write parent, level and stamp
    logic       set_status;
    logic       clear;
    logic       tr_init;    // trace: first next device and found flag
    logic       tr_next;    // trace: next device of the new target
    logic       tr_advance; // trace: target := next, hop++
    logic       tr_ovf;
    logic       out_load;   // load the output register
    logic [1:0] out_kind;   // read, clear, hop or trace final
  } ctrl_t;

  // Status from datapath to controller.
  typedef struct packed {
    logic [1:0] cmd;
    logic       scan_done;
    logic       hit;
    logic       par_ok;
    logic       full;
    logic       accept;
    logic       tr_end;   // next is broadcast or own
    logic       hop_lim;
  } stat_t;

endpackage

// File: hw/rtl/mesh_parent_route_table_core.sv
// Top level of the mesh parent route table.
//  channel | direction | handshake             | word
//  in      | input     | in_valid_i/in_ready_o  | cmd, device, parent, now
//  out     | output    | out_valid_o/out_ready_i| status .. last
//  cfg     | input     | cfg_valid_i/cfg_ready_o| index, data
// One item at a time. A table scan steps through the stored entries and stops at the first match.
// Set parent makes up to three scans (parent, target, target again); get makes one scan,
// and a trace makes one scan more than its hops, with up to seven hops.
// Reset clears the entry count, resets the configuration registers and idles the controller; entries are
// not cleared. A stalled output holds the controller before its next result word.
module mesh_parent_route_table_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  cmd_i,
  input  logic [15:0] device_addr_i,
  input  logic [15:0] parent_addr_i,
  input  logic [31:0] now_ms_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [2:0]  status_o,
  output logic [15:0] addr_out_o,
  output logic [7:0]  level_out_o,
  output logic        found_o,
  output logic [5:0]  hop_count_o,
  output logic        overflow_o,
  output logic        last_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i
);

  mprt_pkg::ctrl_t ctrl;
  mprt_pkg::stat_t stat;

  assign cfg_ready_o = 1'b1;

  mprt_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .out_valid_o, .out_ready_i,
    .stat_i(stat), .ctrl_o(ctrl)
  );

  mprt_datapath u_dp (
    .clk_i, .rst_ni, .ctrl_i(ctrl), .stat_o(stat), .cfg_valid_i, .cfg_index_i,
    .cfg_data_i, .cmd_i, .device_addr_i, .parent_addr_i, .now_ms_i, .status_o,
    .addr_out_o, .level_out_o, .found_o, .hop_count_o, .overflow_o, .last_o
  );

endmodule

// File: hw/rtl/mprt_datapath.sv
// Datapath of the route table: entry store, scan unit and output register.
module mprt_datapath (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  mprt_pkg::ctrl_t      ctrl_i,
  output mprt_pkg::stat_t      stat_o,
  input  logic                 cfg_valid_i,
  input  logic [1:0]           cfg_index_i,
  input  logic [31:0]          cfg_data_i,
  input  logic [1:0]           cmd_i,
  input  logic [15:0]          device_addr_i,
  input  logic [15:0]          parent_addr_i,
  input  logic [31:0]          now_ms_i,
  output logic [2:0]           status_o,
  output logic [15:0]          addr_out_o,
  output logic [7:0]           level_out_o,
  output logic                 found_o,
  output logic [5:0]           hop_count_o,
  output logic                 overflow_o,
  output logic                 last_o
);

  // Entry store, read at one scanned index per cycle.
  logic [15:0] dev_mem [mprt_pkg::MaxEntries];
  logic [15:0] par_mem [mprt_pkg::MaxEntries];
  logic [7:0]  lvl_mem [mprt_pkg::MaxEntries];
  logic [31:0] stp_mem [mprt_pkg::MaxEntries];

  logic [mprt_pkg::CntW-1:0] count_q;
  logic [mprt_pkg::CntW-1:0] scan_q;
  logic [15:0] own_q, bcast_q;
  logic [31:0] live_q;
  logic [1:0]  cmd_q;
  logic [15:0] dev_q, par_q, tgt_q, next_q;
  logic [31:0] now_q;
  logic        hit_q, phit_q, fnd_q, ovf_q;
  logic [mprt_pkg::IdxW-1:0] idx_q;
  logic [7:0]  tlvl_q, plvl_q;
  logic [15:0] tpar_q;
  logic [31:0] tstp_q;
  logic [2:0]  st_q;
  logic [5:0]  hops_q;

  logic [mprt_pkg::IdxW-1:0] sidx;
  logic [15:0] key;
  logic        match, done;
  logic [31:0] age;
  logic [7:0]  newlvl;

  assign sidx  = scan_q[mprt_pkg::IdxW-1:0];
  assign key   = ctrl_i.scan_par ? par_q : tgt_q;
  assign done  = (scan_q >= count_q) || hit_q;
  assign match = !done && (dev_mem[sidx] == key);
  assign age   = now_q - tstp_q;
  assign newlvl = phit_q ? ((plvl_q == 8'hFF) ? 8'hFF : plvl_q + 8'd1) : 8'd1;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      own_q   <= '0;
      bcast_q <= 16'hFFFF;
      live_q  <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        mprt_pkg::RegOwn:   own_q   <= cfg_data_i[15:0];
        mprt_pkg::RegBcast: bcast_q <= cfg_data_i[15:0];
        mprt_pkg::RegLive:  live_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Entry count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (ctrl_i.clear) begin
      count_q <= '0;
    end else if (ctrl_i.create) begin
      count_q <= count_q + 1'b1;
    end
  end

  // Entry writes.
  always_ff @(posedge clk_i) begin
    if (ctrl_i.create) begin
      dev_mem[count_q[mprt_pkg::IdxW-1:0]] <= dev_q;
      par_mem[count_q[mprt_pkg::IdxW-1:0]] <= par_q;
      lvl_mem[count_q[mprt_pkg::IdxW-1:0]] <= newlvl;
      stp_mem[count_q[mprt_pkg::IdxW-1:0]] <= now_q;
    end else if (ctrl_i.update) begin
      par_mem[idx_q] <= par_q;
      lvl_mem[idx_q] <= newlvl;
      stp_mem[idx_q] <= now_q;
    end
  end

  // Command word, scan state and trace state.
  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      cmd_q <= cmd_i;
      dev_q <= device_addr_i;
      par_q <= parent_addr_i;
      now_q <= now_ms_i;
      tgt_q <= device_addr_i;
      hops_q <= '0;
      ovf_q  <= 1'b0;
    end
    if (ctrl_i.scan_start) begin
      scan_q <= '0;
      hit_q  <= 1'b0;
    end else if (ctrl_i.scan_step && !done) begin
      scan_q <= scan_q + 1'b1;
      if (match) begin
        hit_q  <= 1'b1;
        idx_q  <= sidx;
        tlvl_q <= lvl_mem[sidx];
        tpar_q <= par_mem[sidx];
        tstp_q <= stp_mem[sidx];
      end
    end
    if (ctrl_i.latch_par) begin
      phit_q <= hit_q;
      plvl_q <= tlvl_q;
    end
    if (ctrl_i.set_status) begin
      if (!hit_q) begin
        st_q <= (count_q >= mprt_pkg::CntW'(mprt_pkg::MaxEntries)) ?
                mprt_pkg::StError : mprt_pkg::StCreated;
      end else begin
        st_q <= !stat_o.accept ? mprt_pkg::StRejected :
                (tpar_q == par_q) ? mprt_pkg::StIdentical : mprt_pkg::StChanged;
      end
    end else if (ctrl_i.load) begin
      st_q <= mprt_pkg::StError;
    end
    // The found flag belongs to the traced device; the next device follows each scan.
    if (ctrl_i.tr_init) begin
      fnd_q <= hit_q;
    end
    if (ctrl_i.tr_init || ctrl_i.tr_next) begin
      next_q <= hit_q ? tpar_q : bcast_q;
    end
    if (ctrl_i.tr_advance) begin
      tgt_q  <= next_q;
      hops_q <= hops_q + 6'd1;
    end
    if (ctrl_i.tr_ovf) begin
      ovf_q <= 1'b1;
    end
  end

  // Status to controller.
  always_comb begin
    stat_o.cmd       = cmd_q;
    stat_o.scan_done = done;
    stat_o.hit       = hit_q;
    stat_o.par_ok    = (par_q == bcast_q) || (par_q == own_q) || phit_q;
    stat_o.full      = count_q >= mprt_pkg::CntW'(mprt_pkg::MaxEntries);
    stat_o.accept    = (phit_q && (plvl_q < tlvl_q)) || (age > live_q);
    stat_o.tr_end    = (next_q == bcast_q) || (next_q == own_q);
    stat_o.hop_lim   = hops_q >= 6'(mprt_pkg::MaxHops - 1);
  end

  // Output register.
  always_ff @(posedge clk_i) begin
    if (ctrl_i.out_load) begin
      case (ctrl_i.out_kind)
        mprt_pkg::OutRead: begin
          status_o    <= (cmd_q == mprt_pkg::CmdSet) ? st_q : mprt_pkg::StError;
          addr_out_o  <= hit_q ? tpar_q : bcast_q;
          level_out_o <= hit_q ? tlvl_q : 8'd0;
          found_o     <= hit_q;
          hop_count_o <= '0;
          overflow_o  <= 1'b0;
          last_o      <= 1'b1;
        end
        mprt_pkg::OutClear: begin
          status_o    <= mprt_pkg::StError;
          addr_out_o  <= '0;
          level_out_o <= '0;
          found_o     <= 1'b0;
          hop_count_o <= '0;
          overflow_o  <= 1'b0;
          last_o      <= 1'b1;
        end
        mprt_pkg::OutHop: begin
          status_o    <= mprt_pkg::StError;
          addr_out_o  <= tgt_q;
          level_out_o <= '0;
          found_o     <= fnd_q;
          hop_count_o <= '0;
          overflow_o  <= 1'b0;
          last_o      <= 1'b0;
        end
        default: begin
          // Final word of a trace.
          status_o    <= mprt_pkg::StError;
          addr_out_o  <= tgt_q;
          level_out_o <= '0;
          found_o     <= fnd_q;
          hop_count_o <= hops_q;
          overflow_o  <= ovf_q;
          last_o      <= 1'b1;
        end
      endcase
    end
  end

endmodule

// File: hw/rtl/mprt_ctrl.sv
// Controller state machine of the route table.
module mprt_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  input  mprt_pkg::stat_t stat_i,
  output mprt_pkg::ctrl_t ctrl_o
);

  mprt_pkg::state_e state_q, state_d;
  logic ov_q, ov_d;
  logic ret_q, ret_d; // set after a set-parent write or an emitted hop; marks the next scan as a rescan

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= mprt_pkg::StIdle;
      ov_q    <= 1'b0;
      ret_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      ov_q    <= ov_d;
      ret_q   <= ret_d;
    end
  end

  assign out_valid_o = ov_q;

  // Next state and commands.
  always_comb begin
    state_d = state_q;
    ctrl_o  = '0;
    ret_d   = ret_q;
    ov_d    = ov_q && !out_ready_i;
    in_ready_o = 1'b0;
    case (state_q)
      mprt_pkg::StIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          ctrl_o.load       = 1'b1;
          ctrl_o.scan_start = 1'b1;
          state_d = mprt_pkg::StScanPar;
        end
      end
      mprt_pkg::StScanPar: begin
        // Set parent looks up the proposed parent first.
        case (stat_i.cmd)
          mprt_pkg::CmdSet: begin
            ctrl_o.scan_par  = 1'b1;
            ctrl_o.scan_step = 1'b1;
            if (stat_i.scan_done) begin
              ctrl_o.latch_par  = 1'b1;
              ctrl_o.scan_start = 1'b1;
              state_d = mprt_pkg::StScanDev;
            end
          end
          mprt_pkg::CmdClear: begin
            ctrl_o.clear = 1'b1;
            state_d = mprt_pkg::StEmit;
            ret_d = 1'b0;
          end
          mprt_pkg::CmdGet: begin
            state_d = mprt_pkg::StScanDev;
          end
          default: begin
            state_d = mprt_pkg::StTrScan;
          end
        endcase
      end
      mprt_pkg::StScanDev: begin
        ctrl_o.scan_step = 1'b1;
        if (stat_i.scan_done) begin
          if (stat_i.cmd == mprt_pkg::CmdSet && !ret_q && stat_i.par_ok) begin
            state_d = mprt_pkg::StDecide;
          end else begin
            state_d = mprt_pkg::StReadOut;
          end
        end
      end
      mprt_pkg::StDecide: begin
        ctrl_o.set_status = 1'b1;
        if (!stat_i.hit) begin
          if (!stat_i.full) begin
            ctrl_o.create = 1'b1;
          end
        end else if (stat_i.accept) begin
          ctrl_o.update = 1'b1;
        end
        state_d = mprt_pkg::StWrite;
      end
      mprt_pkg::StWrite: begin
        // Rescan the target so the output shows the stored entry.
        ctrl_o.scan_start = 1'b1;
        state_d = mprt_pkg::StScanDev;
        if (stat_i.hit) begin
          state_d = mprt_pkg::StScanDev;
        end
        ret_d = 1'b1;
        // Mark via ret: a second StScanDev pass goes to ReadOut.
      end
      mprt_pkg::StReadOut: begin
        if (!ov_q || out_ready_i) begin
          ctrl_o.out_load = 1'b1;
          ctrl_o.out_kind = mprt_pkg::OutRead;
          ov_d = 1'b1;
          ret_d = 1'b0;
          state_d = mprt_pkg::StIdle;
        end
      end
      mprt_pkg::StEmit: begin
        if (!ov_q || out_ready_i) begin
          ctrl_o.out_load = 1'b1;
          ctrl_o.out_kind = mprt_pkg::OutClear;
          ov_d = 1'b1;
          state_d = mprt_pkg::StIdle;
        end
      end
      mprt_pkg::StTrScan: begin
        ctrl_o.scan_step = 1'b1;
        if (stat_i.scan_done) begin
          if (!ret_q) begin
            ctrl_o.tr_init = 1'b1;
          end else begin
            ctrl_o.tr_next = 1'b1;
          end
          state_d = mprt_pkg::StTrStep;
        end
      end
      mprt_pkg::StTrStep: begin
        if (stat_i.tr_end || stat_i.hop_lim) begin
          if (!ov_q || out_ready_i) begin
            ctrl_o.tr_ovf   = !stat_i.tr_end;
            state_d = mprt_pkg::StTrEmit;
          end
        end else if (!ov_q || out_ready_i) begin
          ctrl_o.out_load = 1'b1;
          ctrl_o.out_kind = mprt_pkg::OutHop;
          ov_d = 1'b1;
          ctrl_o.tr_advance = 1'b1;
          ctrl_o.scan_start = 1'b1;
          ret_d = 1'b1;
          state_d = mprt_pkg::StTrScan;
        end
      end
      mprt_pkg::StTrEmit: begin
        if (!ov_q || out_ready_i) begin
          ctrl_o.out_load = 1'b1;
          ctrl_o.out_kind = mprt_pkg::OutFinal;
          ov_d = 1'b1;
          ret_d = 1'b0;
          state_d = mprt_pkg::StIdle;
        end
      end
      default: state_d = mprt_pkg::StIdle;
    endcase
  end

endmodule

// File: hw/rtl/mprt_checker.sv
// Port checker for the route table, bound to the top level.
module mprt_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_ready_o,
  input logic out_valid_o,
  input logic out_ready_i,
  input logic last_o,
  input logic overflow_o
);

  // Output word holds while stalled.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(last_o))
    else $error("output word dropped while stalled");

  // Ready drops once an item is accepted.
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("item accepted while busy");

  // Overflow only on the last word.
  a_ovf_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && overflow_o |-> last_o)
    else $error("overflow on non-final word");

endmodule

bind mesh_parent_route_table_core mprt_checker u_mprt_checker (
  .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .out_valid_o, .out_ready_i,
  .last_o, .overflow_o
);
